### design/ps2hq_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 host command queue package
// Shared types and codes for the front end, the op queue and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ps2hq_pkg;

  // Result kinds carried on out_tuser.
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_KEY    = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  // Completion status codes.
  localparam logic [1:0] STAT_ACK   = 2'd0;
  localparam logic [1:0] STAT_FAIL  = 2'd1;
  localparam logic [1:0] STAT_ECHO  = 2'd2;
  localparam logic [1:0] STAT_REPLY = 2'd3;

  // Largest scan code that is reported as a key event.
  localparam logic [6:0] KEY_CODE_MAX = 7'h3A;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 32;

  // Classification of a received byte, in order of precedence.
  typedef enum logic [1:0] {
    RX_OTHER  = 2'd0,
    RX_ACK    = 2'd1,
    RX_RESEND = 2'd2,
    RX_ECHO   = 2'd3
  } rx_class_t;

  // One stored command.
  typedef struct packed {
    logic       wants;
    logic [7:0] retries;
    logic [7:0] data;
    logic [7:0] id;
  } cmd_entry_t;

  // A classified input transaction as passed from front to back.
  typedef struct packed {
    logic       is_rx;
    cmd_entry_t cmd;
    logic [7:0] rx_byte;
    rx_class_t  rx_class;
    logic       key_ok;
  } op_t;

endpackage

`default_nettype wire

### design/ps2_host_command_queue_core.sv
// ----------------------------------------------------------------------------
// PS/2 host command queue core
// An accepted op passes from the front register through the op queue into
// the back end, which takes the next op only from its idle state. The command
// store is read in a fetch state before each transmit pair.
// Input is taken into a front register and a two-entry queue while the back
// end works. Reset (rst_n low, synchronous) empties the queue, idles the link.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2_host_command_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter logic [7:0]  ACK_CODE    = 8'd250,
  parameter logic [7:0]  RESEND_CODE = 8'd254,
  parameter logic [7:0]  ECHO_CODE   = 8'd238,
  parameter logic [7:0]  SCANSET_CMD = 8'd240
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // cmd_id[7:0], cmd_data[15:8], cmd_retries[23:16], wants_reply[24],
  // rx_byte[32:25], zero fill above
  input  wire  [ps2hq_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation
  input  wire                              in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // tx_byte[7:0], done_status[9:8], reply_value[17:10], key_code[23:18],
  // key_released[24], zero fill above
  output logic [ps2hq_pkg::OUT_DATA_W-1:0] out_tdata,
  // kind
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast
);
  import ps2hq_pkg::*;

  logic front_valid;
  logic front_ready;
  op_t  front_op;
  logic back_valid;
  logic back_ready;
  op_t  back_op;

  ps2hq_front #(
    .ACK_CODE    (ACK_CODE),
    .RESEND_CODE (RESEND_CODE),
    .ECHO_CODE   (ECHO_CODE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .op_valid  (front_valid),
    .op_ready  (front_ready),
    .op        (front_op)
  );

  ps2hq_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_op    (front_op),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_op     (back_op)
  );

  ps2hq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SCANSET_CMD (SCANSET_CMD)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_valid   (back_valid),
    .op_ready   (back_ready),
    .op         (back_op),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

### design/ps2hq_front.sv
// ----------------------------------------------------------------------------
// PS/2 host command queue front end
// Accepts input transactions, unpacks them and classifies received bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2hq_front #(
  parameter logic [7:0] ACK_CODE    = 8'd250,
  parameter logic [7:0] RESEND_CODE = 8'd254,
  parameter logic [7:0] ECHO_CODE   = 8'd238
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // cmd_id[7:0], cmd_data[15:8], cmd_retries[23:16], wants_reply[24],
  // rx_byte[32:25], zero fill above
  input  wire  [ps2hq_pkg::IN_DATA_W-1:0]   in_tdata,
  // operation
  input  wire                               in_tuser,
  output logic                              op_valid,
  input  wire                               op_ready,
  output ps2hq_pkg::op_t                    op
);
  import ps2hq_pkg::*;

  op_t  op_r;
  op_t  op_nxt;
  logic op_vld_r;

  always_comb begin
    op_nxt.is_rx       = in_tuser;
    op_nxt.cmd.id      = in_tdata[7:0];
    op_nxt.cmd.data    = in_tdata[15:8];
    op_nxt.cmd.retries = in_tdata[23:16];
    op_nxt.cmd.wants   = in_tdata[24];
    op_nxt.rx_byte     = in_tdata[32:25];
    op_nxt.key_ok      = (in_tdata[31:25] <= KEY_CODE_MAX);
    // ACK wins over RESEND, which wins over ECHO, when the codes coincide.
    if (in_tdata[32:25] == ACK_CODE) begin
      op_nxt.rx_class = RX_ACK;
    end else if (in_tdata[32:25] == RESEND_CODE) begin
      op_nxt.rx_class = RX_RESEND;
    end else if (in_tdata[32:25] == ECHO_CODE) begin
      op_nxt.rx_class = RX_ECHO;
    end else begin
      op_nxt.rx_class = RX_OTHER;
    end
  end

  assign in_tready = !op_vld_r || op_ready;
  assign op_valid  = op_vld_r;
  assign op        = op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      op_vld_r <= 1'b1;
    end else if (op_ready) begin
      op_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r <= op_nxt;
    end
  end

endmodule

`default_nettype wire

### design/ps2hq_fifo.sv
// ----------------------------------------------------------------------------
// PS/2 host command queue op queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2hq_fifo (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push_valid,
  output logic            push_ready,
  input  ps2hq_pkg::op_t  push_op,
  output logic            pop_valid,
  input  wire             pop_ready,
  output ps2hq_pkg::op_t  pop_op
);
  import ps2hq_pkg::*;

  op_t        slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       push;
  logic       pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_op     = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

### design/ps2hq_back.sv
// ----------------------------------------------------------------------------
// PS/2 host command queue back end
// Holds the command store and link mode, executes ops and emits results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2hq_back #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter logic [7:0]  SCANSET_CMD = 8'd240
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                op_valid,
  output logic                               op_ready,
  input  ps2hq_pkg::op_t                     op,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // tx_byte[7:0], done_status[9:8], reply_value[17:10], key_code[23:18],
  // key_released[24], zero fill above
  output logic [ps2hq_pkg::OUT_DATA_W-1:0]   out_tdata,
  // kind
  output logic [1:0]                         out_tuser,
  output logic                               out_tlast
);
  import ps2hq_pkg::*;

  localparam int unsigned PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W   = PTR_W + 1;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LOOK   = 7'b0000010,
    ST_DONE   = 7'b0000100,
    ST_FETCH  = 7'b0001000,
    ST_TXID   = 7'b0010000,
    ST_TXDATA = 7'b0100000,
    ST_SINGLE = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_RESP = 3'b010,
    MODE_DATA = 3'b100
  } link_mode_t;

  cmd_entry_t cmd_mem [QUEUE_DEPTH];
  cmd_entry_t rd_data_r;

  state_t     state_r, state_nxt;
  link_mode_t mode_r, mode_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  op_t        op_r;
  logic [1:0] status_r, status_nxt;
  logic [7:0] reply_r, reply_nxt;
  logic       more_r, more_nxt;
  logic [1:0] single_kind_r, single_kind_nxt;

  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  cmd_entry_t       wr_data;
  logic [SUM_W-1:0] tail_sum;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] head_inc;
  logic             is_scanset;

  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]            out_kind_r;
  logic                  out_last_r;
  logic                  can_out;
  logic                  emit;
  logic [OUT_DATA_W-1:0] emit_data;
  logic [1:0]            emit_kind;
  logic                  emit_last;

  assign op_ready = (state_r == ST_IDLE);
  assign can_out  = !out_vld_r || out_tready;

  // Tail is head plus fill, which stays below twice the depth.
  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
  assign head_inc = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
  assign is_scanset = (rd_data_r.id == SCANSET_CMD);

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    status_nxt      = status_r;
    reply_nxt       = reply_r;
    more_nxt        = more_r;
    single_kind_nxt = single_kind_r;
    wr_en           = 1'b0;
    wr_addr         = tail;
    wr_data         = op_r.cmd;
    emit            = 1'b0;
    emit_data       = '0;
    emit_kind       = KIND_TX;
    emit_last       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (op_valid) begin
          state_nxt = ST_LOOK;
        end
      end

      ST_LOOK: begin
        state_nxt = ST_IDLE;
        if (!op_r.is_rx) begin
          if (count_r == COUNT_W'(QUEUE_DEPTH)) begin
            single_kind_nxt = KIND_REJECT;
            state_nxt       = ST_SINGLE;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + COUNT_W'(1);
            if (mode_r == MODE_IDLE) begin
              // Idle implies an empty store, so the new entry is the head.
              mode_nxt  = MODE_RESP;
              state_nxt = ST_FETCH;
            end
          end
        end else if (mode_r == MODE_IDLE || count_r == '0 ||
                     (mode_r == MODE_RESP && op_r.rx_class == RX_OTHER)) begin
          if (op_r.key_ok) begin
            single_kind_nxt = KIND_KEY;
            state_nxt       = ST_SINGLE;
          end
        end else begin
          // Default is a completion; the cases below override it.
          more_nxt   = (count_r > COUNT_W'(1));
          status_nxt = STAT_REPLY;
          reply_nxt  = op_r.rx_byte;
          if (mode_r == MODE_RESP) begin
            reply_nxt = '0;
            case (op_r.rx_class)
              RX_ACK:    status_nxt = STAT_ACK;
              RX_RESEND: status_nxt = STAT_FAIL;
              default:   status_nxt = STAT_ECHO;
            endcase
          end
          if (mode_r == MODE_RESP && is_scanset &&
              (op_r.rx_class == RX_ACK || op_r.rx_class == RX_RESEND)) begin
            mode_nxt = MODE_DATA;
          end else if (mode_r == MODE_RESP && op_r.rx_class == RX_RESEND &&
                       rd_data_r.retries != '0) begin
            wr_en           = 1'b1;
            wr_addr         = head_r;
            wr_data         = rd_data_r;
            wr_data.retries = rd_data_r.retries - 8'd1;
            state_nxt       = ST_FETCH;
          end else begin
            head_nxt  = head_inc;
            count_nxt = count_r - COUNT_W'(1);
            mode_nxt  = more_nxt ? MODE_RESP : MODE_IDLE;
            if (rd_data_r.wants) begin
              state_nxt = ST_DONE;
            end else if (more_nxt) begin
              state_nxt = ST_FETCH;
            end
          end
        end
      end

      ST_DONE: begin
        if (can_out) begin
          emit      = 1'b1;
          emit_kind = KIND_DONE;
          emit_data = {7'd0, 1'b0, 6'd0, reply_r, status_r, 8'd0};
          emit_last = !more_r;
          state_nxt = more_r ? ST_FETCH : ST_IDLE;
        end
      end

      ST_FETCH: begin
        // The head entry is read during this cycle.
        state_nxt = ST_TXID;
      end

      ST_TXID: begin
        if (can_out) begin
          emit      = 1'b1;
          emit_kind = KIND_TX;
          emit_data = {24'd0, rd_data_r.id};
          state_nxt = ST_TXDATA;
        end
      end

      ST_TXDATA: begin
        if (can_out) begin
          emit      = 1'b1;
          emit_kind = KIND_TX;
          emit_data = {24'd0, rd_data_r.data};
          emit_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_SINGLE: begin
        if (can_out) begin
          emit      = 1'b1;
          emit_kind = single_kind_r;
          emit_last = 1'b1;
          if (single_kind_r == KIND_KEY) begin
            emit_data = {7'd0, op_r.rx_byte[7], op_r.rx_byte[5:0], 18'd0};
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= MODE_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r      <= status_nxt;
    reply_r       <= reply_nxt;
    more_r        <= more_nxt;
    single_kind_r <= single_kind_nxt;
    if (op_valid && op_ready) begin
      op_r <= op;
    end
    if (emit) begin
      out_data_r <= emit_data;
      out_kind_r <= emit_kind;
      out_last_r <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cmd_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= cmd_mem[head_r];
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

### bench/ps2_host_command_queue_core_tb.sv
// ----------------------------------------------------------------------------
// PS/2 host command queue core testbench
// Drives host commands and received keyboard bytes into the core through the
// input stream. A behavioral model of the queue and the link mode predicts
// every transmit byte, completion, key event and rejection. The bench then
// checks each result field by field against the oldest prediction, with
// random idling and stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2_host_command_queue_core_tb;
  import ps2hq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam logic [7:0]  ACK_CODE    = 8'hFA;
  localparam logic [7:0]  RESEND_CODE = 8'hFE;
  localparam logic [7:0]  ECHO_CODE   = 8'hEE;
  localparam logic [7:0]  SCANSET_CMD = 8'hF0;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_RX      = 1'b1;

  localparam logic [7:0] COMMON_IDS [4] = '{8'hED, 8'hEE, 8'hF3, 8'hFF};

  typedef enum logic [1:0] {
    LINK_IDLE = 2'd0,
    LINK_RESP = 2'd1,
    LINK_DATA = 2'd2
  } link_state_t;

  typedef struct {
    logic       op;
    logic [7:0] id;
    logic [7:0] data;
    logic [7:0] retries;
    logic       wants;
    logic [7:0] rx;
    bit         drain;
  } host_item_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] tx;
    logic [1:0] status;
    logic [7:0] reply;
    logic [5:0] code;
    logic       released;
    logic       last;
  } link_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tready = 1'b0;
  wire                   in_tready;
  wire                   out_tvalid;
  wire [OUT_DATA_W-1:0]  out_tdata;
  wire [1:0]             out_tuser;
  wire                   out_tlast;

  // Stimulus and scoreboard.
  host_item_t   host_items[$];
  host_item_t   current_item;
  link_result_t link_results_due[$];
  link_result_t step_results[$];
  bit           drain_next;
  int unsigned  item_total;
  int unsigned  offered_cnt;
  int unsigned  taken_cnt;
  int unsigned  result_cnt;
  int unsigned  mismatches;
  int unsigned  kind_seen [4];

  // Model state.
  cmd_entry_t   cmd_slots [QUEUE_DEPTH];
  int unsigned  slot_head;
  int unsigned  slot_count;
  link_state_t  link_state;

  // Idling state.
  int unsigned  send_gap;
  int unsigned  send_steady;
  int unsigned  stall_left;
  int unsigned  recv_steady;
  int unsigned  hold_left;
  bit           hold_done;

  ps2_host_command_queue_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ACK_CODE    (ACK_CODE),
    .RESEND_CODE (RESEND_CODE),
    .ECHO_CODE   (ECHO_CODE),
    .SCANSET_CMD (SCANSET_CMD)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic void push_result(logic [1:0] kind, logic [7:0] tx, logic [1:0] status,
                                      logic [7:0] reply, logic [5:0] code, logic released);
    link_result_t r;
    r.kind     = kind;
    r.tx       = tx;
    r.status   = status;
    r.reply    = reply;
    r.code     = code;
    r.released = released;
    r.last     = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void send_cmd_bytes(cmd_entry_t c);
    push_result(KIND_TX, c.id, STAT_ACK, 8'd0, 6'd0, 1'b0);
    push_result(KIND_TX, c.data, STAT_ACK, 8'd0, 6'd0, 1'b0);
  endfunction

  // Bit 7 marks a release; codes past the table end are dropped.
  function automatic void report_key(logic [7:0] b);
    if (b[6:0] <= KEY_CODE_MAX) begin
      push_result(KIND_KEY, 8'd0, STAT_ACK, 8'd0, b[5:0], b[7]);
    end
  endfunction

  function automatic void send_next_cmd();
    if (slot_count == 0) begin
      link_state = LINK_IDLE;
    end else begin
      link_state = LINK_RESP;
      send_cmd_bytes(cmd_slots[slot_head]);
    end
  endfunction

  function automatic void finish_head(logic [1:0] status, logic [7:0] reply);
    if (cmd_slots[slot_head].wants) begin
      push_result(KIND_DONE, 8'd0, status, reply, 6'd0, 1'b0);
    end
    if (slot_count != 0) begin
      slot_head  = (slot_head + 1) % QUEUE_DEPTH;
      slot_count = slot_count - 1;
    end
    send_next_cmd();
  endfunction

  // Updates the model with one accepted transaction and queues its results.
  function automatic void apply_host_item(host_item_t it);
    int unsigned tail;
    step_results.delete();
    if (it.op == OP_ENQUEUE) begin
      if (slot_count >= QUEUE_DEPTH) begin
        push_result(KIND_REJECT, 8'd0, STAT_ACK, 8'd0, 6'd0, 1'b0);
      end else begin
        tail = (slot_head + slot_count) % QUEUE_DEPTH;
        cmd_slots[tail].id      = it.id;
        cmd_slots[tail].data    = it.data;
        cmd_slots[tail].retries = it.retries;
        cmd_slots[tail].wants   = it.wants;
        slot_count = slot_count + 1;
        if (link_state == LINK_IDLE) begin
          link_state = LINK_RESP;
          send_cmd_bytes(cmd_slots[tail]);
        end
      end
    end else if (link_state == LINK_IDLE || slot_count == 0) begin
      report_key(it.rx);
    end else if (link_state == LINK_RESP) begin
      if (it.rx == ACK_CODE) begin
        if (cmd_slots[slot_head].id == SCANSET_CMD) link_state = LINK_DATA;
        else finish_head(STAT_ACK, 8'd0);
      end else if (it.rx == RESEND_CODE) begin
        // A scan-code-set command goes on to its data byte without using a retry.
        if (cmd_slots[slot_head].id == SCANSET_CMD) begin
          link_state = LINK_DATA;
        end else if (cmd_slots[slot_head].retries == 8'd0) begin
          finish_head(STAT_FAIL, 8'd0);
        end else begin
          cmd_slots[slot_head].retries = cmd_slots[slot_head].retries - 8'd1;
          send_next_cmd();
        end
      end else if (it.rx == ECHO_CODE) begin
        finish_head(STAT_ECHO, 8'd0);
      end else begin
        report_key(it.rx);
      end
    end else begin
      finish_head(STAT_REPLY, it.rx);
    end
    if (step_results.size() > 0) step_results[$].last = 1'b1;
    foreach (step_results[k]) link_results_due.push_back(step_results[k]);
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic void add_cmd(logic [7:0] id, logic [7:0] data, logic [7:0] retries,
                                  logic wants);
    host_item_t it;
    it.op      = OP_ENQUEUE;
    it.id      = id;
    it.data    = data;
    it.retries = retries;
    it.wants   = wants;
    it.rx      = 8'($urandom_range(0, 255));
    it.drain   = drain_next;
    drain_next = 1'b0;
    host_items.push_back(it);
    item_total = item_total + 1;
  endfunction

  function automatic void add_rx(logic [7:0] b);
    host_item_t it;
    it.op      = OP_RX;
    it.id      = 8'($urandom_range(0, 255));
    it.data    = 8'($urandom_range(0, 255));
    it.retries = 8'($urandom_range(0, 255));
    it.wants   = 1'($urandom_range(0, 1));
    it.rx      = b;
    it.drain   = drain_next;
    drain_next = 1'b0;
    host_items.push_back(it);
    item_total = item_total + 1;
  endfunction

  function automatic void add_random_cmd();
    int unsigned r;
    logic [7:0]  id;
    logic [7:0]  retries;
    r = $urandom_range(0, 99);
    if (r < 30) id = SCANSET_CMD;
    else if (r < 45) id = COMMON_IDS[$urandom_range(0, 3)];
    else id = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 85) retries = 8'($urandom_range(0, 3));
    else retries = 8'($urandom_range(0, 255));
    add_cmd(id, 8'($urandom_range(0, 255)), retries, $urandom_range(0, 99) < 80);
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    logic                 nxt_valid;
    logic [IN_DATA_W-1:0] nxt_data;
    logic                 nxt_user;
    host_item_t           it;
    nxt_valid = in_tvalid;
    nxt_data  = in_tdata;
    nxt_user  = in_tuser;
    if (rst_n && (!in_tvalid || offered_cnt == taken_cnt)) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
      end else if (host_items.size() > 0 &&
                   !(host_items[0].drain && link_results_due.size() > 0)) begin
        it           = host_items.pop_front();
        current_item = it;
        nxt_valid    = 1'b1;
        nxt_data     = {7'd0, it.rx, it.wants, it.retries, it.data, it.id};
        nxt_user     = it.op;
        offered_cnt  = offered_cnt + 1;
        if (send_steady > 0) begin
          send_steady = send_steady - 1;
          send_gap    = 0;
        end else if ($urandom_range(0, 99) < 6) begin
          send_steady = $urandom_range(10, 30);
          send_gap    = 0;
        end else begin
          send_gap = pick_idle_len();
        end
      end
    end
    in_tvalid <= nxt_valid;
    in_tdata  <= nxt_data;
    in_tuser  <= nxt_user;
  end

  // The receiver holds off once for a long stretch so that the core fills up.
  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (!hold_done && taken_cnt >= 45) begin
      hold_left = 300;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      nxt_ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      nxt_ready  = 1'b0;
    end else if (recv_steady > 0) begin
      recv_steady = recv_steady - 1;
    end else if ($urandom_range(0, 99) < 5) begin
      recv_steady = $urandom_range(20, 50);
    end else begin
      stall_left = pick_idle_len();
    end
    out_tready <= nxt_ready;
  end

  // --------------------------------------------------------------- monitor

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp, act);
      mismatches = mismatches + 1;
    end
  endfunction

  always @(posedge clk) begin
    link_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        apply_host_item(current_item);
        taken_cnt = taken_cnt + 1;
      end
      if (out_tvalid && out_tready) begin
        result_cnt = result_cnt + 1;
        kind_seen[out_tuser] = kind_seen[out_tuser] + 1;
        if (link_results_due.size() == 0) begin
          $display("%0t ns: result with no expectation, expected none, actual kind %0d data 0x%0h",
                   $time, out_tuser, out_tdata);
          mismatches = mismatches + 1;
        end else begin
          want = link_results_due.pop_front();
          check_field("kind", want.kind, out_tuser);
          check_field("tx_byte", want.tx, out_tdata[7:0]);
          check_field("done_status", want.status, out_tdata[9:8]);
          check_field("reply_value", want.reply, out_tdata[17:10]);
          check_field("key_code", want.code, out_tdata[23:18]);
          check_field("key_released", want.released, out_tdata[24]);
          check_field("fill", 0, out_tdata[31:25]);
          check_field("last", want.last, out_tlast);
        end
      end
    end
  end

  // ------------------------------------------------------------- sequence

  initial begin
    int unsigned roll;
    int unsigned random_cnt;
    int unsigned burst;

    slot_head  = 0;
    slot_count = 0;
    link_state = LINK_IDLE;

    // Directed part: key filter edges, failure, retry, silent completion,
    // scan-code-set replies after ACK and after RESEND, echo, full queue.
    add_rx(8'h00);
    add_rx(8'hBA);
    add_rx(8'h3B);
    add_cmd(8'hED, 8'h02, 8'd0, 1'b1);
    add_rx(8'h05);
    add_rx(RESEND_CODE);
    add_cmd(8'hF3, 8'hFF, 8'd2, 1'b0);
    add_cmd(SCANSET_CMD, 8'h02, 8'd0, 1'b1);
    add_rx(RESEND_CODE);
    add_rx(ACK_CODE);
    add_rx(ACK_CODE);
    add_rx(8'h41);
    add_cmd(8'hEE, 8'h00, 8'hFF, 1'b1);
    add_rx(ECHO_CODE);
    add_cmd(SCANSET_CMD, 8'h01, 8'd1, 1'b1);
    add_rx(RESEND_CODE);
    add_rx(ACK_CODE);
    add_cmd(8'hFF, 8'hFF, 8'hFF, 1'b1);
    add_cmd(8'h00, 8'h00, 8'h00, 1'b0);
    repeat (7) add_random_cmd();

    // Random part, opened by a pause until all results are in.
    drain_next = 1'b1;
    random_cnt = 0;
    while (random_cnt < 84) begin
      roll = $urandom_range(0, 99);
      if (random_cnt == 60) drain_next = 1'b1;
      if (roll < 4) begin
        burst = $urandom_range(6, 10);
        repeat (burst) add_random_cmd();
        random_cnt = random_cnt + burst;
      end else begin
        if (roll < 34) add_random_cmd();
        else if (roll < 58) add_rx(ACK_CODE);
        else if (roll < 70) add_rx(RESEND_CODE);
        else if (roll < 77) add_rx(ECHO_CODE);
        else if (roll < 90) add_rx({1'($urandom_range(0, 1)), 7'($urandom_range(0, 63))});
        else add_rx(8'($urandom_range(0, 255)));
        random_cnt = random_cnt + 1;
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (taken_cnt != item_total) @(negedge clk);
    while (link_results_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Sent %0d host transactions; checked %0d results with %0d mismatches.",
             taken_cnt, result_cnt, mismatches);
    $display("Results: %0d transmit bytes, %0d completions, %0d key events, %0d rejections.",
             kind_seen[KIND_TX], kind_seen[KIND_DONE], kind_seen[KIND_KEY],
             kind_seen[KIND_REJECT]);
    if (mismatches == 0 && link_results_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3_200_000;
    $display("Timeout with %0d of %0d transactions accepted and %0d results outstanding.",
             taken_cnt, item_total, link_results_due.size());
    $display("simulation failed");
    $finish;
  end

endmodule
